### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while out of reset.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, reset cycles included.
`define AST_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cam_pkg.sv
package cam_pkg;

  // Automaton and counter bank size
  localparam int MAX_STATES   = 64;
  localparam int NUM_COUNTERS = 4;
  localparam int COUNTER_BITS = 16;

  // Fixed field widths of the stream words
  localparam int STATE_W  = 6;
  localparam int MASK_W   = 4;
  localparam int CIDX_F_W = 2;
  localparam int TGT_W    = 16;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 8;

  // Derived sizes
  localparam int EDGE_DEPTH = 2 * MAX_STATES;
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
  localparam int WALK_W     = $clog2(NUM_COUNTERS + 1);
  localparam int CIDX_W     = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  typedef enum logic [1:0] {
    CMD_STEP    = 2'd0,
    CMD_EDGE    = 2'd1,
    CMD_TARGET  = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } cam_state_t;

  // One edge table entry
  typedef struct packed {
    logic [STATE_W-1:0] to;
    logic               acc;
    logic [MASK_W-1:0]  rmask;
    logic [MASK_W-1:0]  imask;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

  // One input word, unpacked
  typedef struct packed {
    cmd_t                cmd;
    logic                bit_in;
    logic [STATE_W-1:0]  sidx;
    logic [STATE_W-1:0]  nxt;
    logic                acc;
    logic [MASK_W-1:0]   rmask;
    logic [MASK_W-1:0]   imask;
    logic [CIDX_F_W-1:0] cidx;
    logic [TGT_W-1:0]    tgt;
  } item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              walk;
    logic              walk_first;
    logic [WALK_W-1:0] walk_idx;
    logic              finish;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_is_step;
    logic slot_free;
  } sts_t;

endpackage

### rtl/cam_ram.sv
module cam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cam_ctrl.sv
module cam_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cam_pkg::sts_t sts,
  output cam_pkg::ctl_t ctl
);

  cam_pkg::cam_state_t         state_r, state_nxt;
  logic [cam_pkg::WALK_W-1:0]  walk_cnt_r, walk_cnt_nxt;
  logic                        walk_last;

  assign walk_last = (walk_cnt_r == cam_pkg::WALK_W'(cam_pkg::NUM_COUNTERS));

  // Next state and walk position
  always_comb begin
    state_nxt    = state_r;
    walk_cnt_nxt = walk_cnt_r;
    unique case (state_r)
      cam_pkg::ST_IDLE: begin
        walk_cnt_nxt = '0;
        if (in_tvalid) begin
          state_nxt = sts.in_is_step ? cam_pkg::ST_WALK : cam_pkg::ST_DONE;
        end
      end
      cam_pkg::ST_WALK: begin
        if (walk_last) begin
          state_nxt    = cam_pkg::ST_DONE;
          walk_cnt_nxt = '0;
        end else begin
          walk_cnt_nxt = walk_cnt_r + 1'b1;
        end
      end
      cam_pkg::ST_DONE: begin
        if (sts.slot_free) begin
          state_nxt = cam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cam_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_tready      = 1'b0;
    ctl.load       = 1'b0;
    ctl.walk       = 1'b0;
    ctl.walk_first = 1'b0;
    ctl.walk_idx   = walk_cnt_r;
    ctl.finish     = 1'b0;
    unique case (state_r)
      cam_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        ctl.load  = in_tvalid;
      end
      cam_pkg::ST_WALK: begin
        ctl.walk       = 1'b1;
        ctl.walk_first = (walk_cnt_r == '0);
      end
      cam_pkg::ST_DONE: begin
        ctl.finish = sts.slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cam_pkg::ST_IDLE;
      walk_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      walk_cnt_r <= walk_cnt_nxt;
    end
  end

endmodule

### rtl/cam_dpath.sv
module cam_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cam_pkg::IN_W-1:0]  in_tdata,
  input  logic [1:0]                in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [cam_pkg::OUT_W-1:0] out_tdata,
  input  cam_pkg::ctl_t             ctl,
  output cam_pkg::sts_t             sts
);

  cam_pkg::item_t                  item_in, item_r;
  logic [cam_pkg::STATE_W-1:0]     state_r, state_nxt;
  logic                            acc_r, acc_nxt;
  logic [cam_pkg::COUNTER_BITS-1:0] cnt_r   [cam_pkg::NUM_COUNTERS];
  logic [cam_pkg::COUNTER_BITS-1:0] cnt_nxt [cam_pkg::NUM_COUNTERS];
  logic [cam_pkg::COUNTER_BITS-1:0] cnt_clr [cam_pkg::NUM_COUNTERS];
  logic [cam_pkg::COUNTER_BITS-1:0] cnt_upd [cam_pkg::NUM_COUNTERS];
  logic [cam_pkg::TGT_W-1:0]       tgt_r   [cam_pkg::NUM_COUNTERS];
  logic                            null_r;
  logic [cam_pkg::EDGE_W-1:0]      rd_data;
  cam_pkg::edge_t                  eff_edge, wr_edge;
  logic [cam_pkg::STATE_W-1:0]     src_state;
  logic [cam_pkg::CIDX_W-1:0]      walk_cidx;
  logic                            walk_last, sat, bit_sel;
  logic [cam_pkg::EDGE_AW-1:0]     raddr, waddr;
  logic                            edge_we, tgt_we;
  logic [cam_pkg::NUM_COUNTERS-1:0] rm_v, im_v;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_acc_r;
  logic [cam_pkg::STATE_W-1:0]     out_state_r;

  // Unpack the input word
  assign item_in.cmd    = cam_pkg::cmd_t'(in_tuser);
  assign item_in.bit_in = in_tdata[0];
  assign item_in.sidx   = in_tdata[6:1];
  assign item_in.nxt    = in_tdata[12:7];
  assign item_in.acc    = in_tdata[13];
  assign item_in.rmask  = in_tdata[17:14];
  assign item_in.imask  = in_tdata[21:18];
  assign item_in.cidx   = in_tdata[23:22];
  assign item_in.tgt    = in_tdata[39:24];

  assign sts.in_is_step = (item_in.cmd == cam_pkg::CMD_STEP);
  assign sts.slot_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= item_in;
    end
  end

  // Edge read back; a lookup from a state past the table reads as all zero
  assign eff_edge  = null_r ? '0 : cam_pkg::edge_t'(rd_data);
  assign src_state = ctl.walk_first ? state_r : eff_edge.to;

  // Pick the edge bit: counter match during the walk, input bit at the end
  assign walk_cidx = ctl.walk_idx[cam_pkg::CIDX_W-1:0];
  assign walk_last = (ctl.walk_idx == cam_pkg::WALK_W'(cam_pkg::NUM_COUNTERS));
  assign sat       = (32'(cnt_r[walk_cidx]) == 32'(tgt_r[walk_cidx]));
  assign bit_sel   = walk_last ? item_r.bit_in : sat;
  assign raddr     = cam_pkg::EDGE_AW'({src_state, bit_sel});

  always_ff @(posedge clk) begin
    if (ctl.walk) begin
      null_r <= (32'(src_state) >= cam_pkg::MAX_STATES);
    end
  end

  // Edge table writes
  assign wr_edge.to    = item_r.nxt;
  assign wr_edge.acc   = item_r.acc;
  assign wr_edge.rmask = item_r.rmask;
  assign wr_edge.imask = item_r.imask;
  assign waddr   = cam_pkg::EDGE_AW'({item_r.sidx, item_r.bit_in});
  assign edge_we = ctl.finish && (item_r.cmd == cam_pkg::CMD_EDGE)
                   && (32'(item_r.sidx) < cam_pkg::MAX_STATES);

  cam_ram #(
    .WIDTH (cam_pkg::EDGE_W),
    .DEPTH (cam_pkg::EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (waddr),
    .wdata (wr_edge),
    .re    (ctl.walk),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Counter update for the input edge: clear, then saturating increment
  assign rm_v = cam_pkg::NUM_COUNTERS'(eff_edge.rmask);
  assign im_v = cam_pkg::NUM_COUNTERS'(eff_edge.imask);

  always_comb begin
    for (int i = 0; i < cam_pkg::NUM_COUNTERS; i++) begin
      cnt_clr[i] = rm_v[i] ? '0 : cnt_r[i];
      cnt_upd[i] = (im_v[i] && (cnt_clr[i] != cam_pkg::CNT_MAX)) ?
                   cnt_clr[i] + 1'b1 : cnt_clr[i];
    end
  end

  // Apply the command at the end of the item
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    tgt_we    = 1'b0;
    if (ctl.finish) begin
      unique case (item_r.cmd)
        cam_pkg::CMD_STEP: begin
          state_nxt = eff_edge.to;
          acc_nxt   = eff_edge.acc;
          cnt_nxt   = cnt_upd;
        end
        cam_pkg::CMD_EDGE: begin
          state_nxt = state_r;
        end
        cam_pkg::CMD_TARGET: begin
          tgt_we = (32'(item_r.cidx) < cam_pkg::NUM_COUNTERS);
        end
        cam_pkg::CMD_RESTART: begin
          state_nxt = '0;
          acc_nxt   = 1'b0;
          for (int i = 0; i < cam_pkg::NUM_COUNTERS; i++) begin
            cnt_nxt[i] = '0;
          end
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      acc_r   <= 1'b0;
      for (int i = 0; i < cam_pkg::NUM_COUNTERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_r[item_r.cidx[cam_pkg::CIDX_W-1:0]] <= item_r.tgt;
    end
  end

  // Output register: load on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_acc_r   <= acc_nxt;
      out_state_r <= state_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_state_r, out_acc_r};

endmodule

### rtl/counter_automaton_monitor.sv
// Counter automaton monitor.
// Input channel in_*: one word per command. in_tuser carries the command
// (step, write edge, write counter target, restart); in_tdata carries the
// step bit or the table write payload. Result channel out_*: exactly one
// word per input word, holding the accept flag and the current state.
// A step walks the edge table once per counter and once more for the input
// bit, one lookup per cycle through the single read port of the edge RAM,
// and then applies the last edge read; writes and restart skip the walk
// and go straight from acceptance to that final update.
// One word is in flight at a time; a finished result sits in the output
// register while the next word is accepted and worked on, and the block
// holds before its final update while that register is still full.
// Reset clears state, accept flag, counters and the output register; the
// edge table and the targets must be written before a step reads them.
`include "assert_macros.svh"

module counter_automaton_monitor (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [0] input_bit, [6:1] state_index, [12:7] next_state, [13] accept_value,
  // [17:14] reset_mask, [21:18] inc_mask, [23:22] counter_index,
  // [39:24] target_value
  input  logic [cam_pkg::IN_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [1:0]                in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [0] accepting, [6:1] state_now, [7] zero
  output logic [cam_pkg::OUT_W-1:0] out_tdata
);

  cam_pkg::ctl_t ctl;
  cam_pkg::sts_t sts;

  cam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  cam_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .ctl        (ctl),
    .sts        (sts)
  );

  // One word at a time: no accept right after an accept
  `AST_CLK(a_one_word, (in_tvalid && in_tready) |=> !in_tready, "second word accepted early")
  // Never overwrite a result that is still waiting
  `AST_CLK(a_no_overrun, ctl.finish |-> (!out_tvalid || out_tready), "result overwritten")
  // A walk starts right after the step word is loaded
  `AST_CLK(a_walk_start, (ctl.walk && ctl.walk_first) |-> $past(ctl.load), "walk without load")
  // Reset empties the output register
  `AST_ANY(a_rst_out, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

### tb/cam_checker.sv
`timescale 1ns / 100ps

// Watch both channels of the counter automaton monitor, run a private copy of
// the automaton on every accepted command word and compare each result word
// with the oldest predicted report.
module cam_checker
  import cam_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  // Command word layout, lowest field last
  typedef struct packed {
    logic [TGT_W-1:0]    tgt;
    logic [CIDX_F_W-1:0] cidx;
    logic [MASK_W-1:0]   imask;
    logic [MASK_W-1:0]   rmask;
    logic                acc;
    logic [STATE_W-1:0]  nxt;
    logic [STATE_W-1:0]  sidx;
    logic                bit_in;
  } cmd_word_t;

  // Result word layout: [0] accepting, [6:1] state_now, [7] pad
  typedef struct packed {
    logic               pad;
    logic [STATE_W-1:0] st;
    logic               acc;
  } report_t;

  edge_t                   edge_mem [EDGE_DEPTH];
  logic [COUNTER_BITS-1:0] tgt_mem  [NUM_COUNTERS];
  logic [COUNTER_BITS-1:0] cnt      [NUM_COUNTERS];
  logic [STATE_W-1:0]      auto_state;
  logic                    acc_flag;
  report_t                 due_reports [$];

  initial begin
    foreach (edge_mem[k]) edge_mem[k] = '0;
    foreach (tgt_mem[k]) tgt_mem[k] = '0;
    foreach (cnt[k]) cnt[k] = '0;
    auto_state  = '0;
    acc_flag    = 1'b0;
    mismatches  = 0;
    outstanding = 0;
  end

  // Clear the run: state, accept flag and counters; tables are kept
  task automatic clear_run();
    foreach (cnt[k]) cnt[k] = '0;
    auto_state = '0;
    acc_flag   = 1'b0;
  endtask

  // Advance the automaton by one command word and queue the report it yields
  task automatic run_automaton(input cmd_t op, input logic [IN_W-1:0] w);
    cmd_word_t f;
    edge_t     e;
    logic      sat;
    report_t   rpt;
    f = w;
    case (op)
      CMD_STEP: begin
        // walk one edge per counter, the 1 edge when the counter hits its target
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          sat = (cnt[i] == tgt_mem[i]);
          auto_state = edge_mem[{auto_state, sat}].to;
        end
        // then the edge picked by the observed bit
        e = edge_mem[{auto_state, f.bit_in}];
        auto_state = e.to;
        acc_flag   = e.acc;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          if (e.rmask[i]) cnt[i] = '0;
        end
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          if (e.imask[i] && cnt[i] != CNT_MAX) cnt[i] = cnt[i] + 1'b1;
        end
      end
      CMD_EDGE: begin
        e.to    = f.nxt;
        e.acc   = f.acc;
        e.rmask = f.rmask;
        e.imask = f.imask;
        edge_mem[{f.sidx, f.bit_in}] = e;
      end
      CMD_TARGET: tgt_mem[f.cidx] = f.tgt;
      CMD_RESTART: clear_run();
      default: ;
    endcase
    rpt.pad = 1'b0;
    rpt.st  = auto_state;
    rpt.acc = acc_flag;
    due_reports.insert(due_reports.size(), rpt);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Compare result words first, then take in the newly accepted command word
  always @(posedge clk) begin : watch
    report_t want;
    report_t got;
    if (!rst_n) begin
      clear_run();
      due_reports.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (due_reports.size() == 0) begin
          $error("result word %h with no prediction waiting", out_tdata);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          check_field("accepting", 32'(want.acc), 32'(got.acc));
          check_field("state_now", 32'(want.st), 32'(got.st));
          check_field("pad", 32'(want.pad), 32'(got.pad));
        end
      end
      if (in_tvalid && in_tready) run_automaton(cmd_t'(in_tuser), in_tdata);
    end
    outstanding = due_reports.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import cam_pkg::*;

  // Cycles without a word passing on either channel before the run is declared hung
  localparam int unsigned IDLE_LIMIT = 4000;
  // Steps in the closing counting run
  localparam int unsigned SOAK_STEPS = 20;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;
  logic [1:0]         in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;
  int unsigned        mismatches;
  int unsigned        outstanding;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        quiet_cycles;

  counter_automaton_monitor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  cam_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hang detection
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [IN_W-1:0] noise_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[IN_W-1:0];
  endfunction

  function automatic logic [IN_W-1:0] step_word(input logic b);
    logic [IN_W-1:0] w;
    w = noise_word();
    w[0] = b;
    return w;
  endfunction

  function automatic logic [IN_W-1:0] edge_word(input logic b, input logic [5:0] s,
                                                input logic [5:0] nx, input logic a,
                                                input logic [3:0] rm, input logic [3:0] im);
    logic [IN_W-1:0] w;
    w = noise_word();
    w[21:0] = {im, rm, a, nx, s, b};
    return w;
  endfunction

  function automatic logic [IN_W-1:0] target_word(input logic [1:0] ci,
                                                  input logic [15:0] tv);
    logic [IN_W-1:0] w;
    w = noise_word();
    w[39:22] = {tv, ci};
    return w;
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input cmd_t op, input logic [IN_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = w;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Hold the sender until every predicted report has come back
  task automatic drain_reports();
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly steps over a fully written table, with edge and target rewrites and restarts mixed in
  task automatic send_mix(input int unsigned n);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_word(CMD_STEP, noise_word());
      end else if (r < 82) begin
        send_word(CMD_EDGE, edge_word(1'($urandom_range(1)), 6'($urandom_range(63)),
                                      6'($urandom_range(63)), 1'($urandom_range(1)),
                                      4'($urandom_range(15)), 4'($urandom_range(15))));
      end else if (r < 92) begin
        // mostly small targets so the counters actually reach them
        send_word(CMD_TARGET, target_word(2'($urandom_range(3)),
                  16'(($urandom_range(4) == 0) ? $urandom_range(65535)
                                               : $urandom_range(7))));
      end else begin
        send_word(CMD_RESTART, noise_word());
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = CMD_STEP;
    out_tready    = 1'b0;
    quiet_cycles  = 0;
    send_idle_pct = 6;
    recv_idle_pct = 82;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: targets at both ends, edges only on states 0 and 63
    send_word(CMD_TARGET, target_word(2'd0, 16'h0000));
    send_word(CMD_TARGET, target_word(2'd1, 16'h0001));
    send_word(CMD_TARGET, target_word(2'd2, 16'hFFFF));
    send_word(CMD_TARGET, target_word(2'd3, 16'h0002));
    // clear and increment every counter on one edge
    send_word(CMD_EDGE, edge_word(1'b0, 6'd0, 6'd63, 1'b1, 4'hF, 4'hF));
    send_word(CMD_EDGE, edge_word(1'b1, 6'd0, 6'd0, 1'b0, 4'h0, 4'h5));
    send_word(CMD_EDGE, edge_word(1'b0, 6'd63, 6'd0, 1'b0, 4'h0, 4'hA));
    send_word(CMD_EDGE, edge_word(1'b1, 6'd63, 6'd63, 1'b1, 4'h3, 4'h0));
    send_word(CMD_STEP, step_word(1'b0));
    send_word(CMD_STEP, step_word(1'b1));
    send_word(CMD_STEP, step_word(1'b1));
    send_word(CMD_STEP, step_word(1'b0));
    send_word(CMD_STEP, step_word(1'b0));
    send_word(CMD_STEP, step_word(1'b1));
    send_word(CMD_RESTART, noise_word());
    send_word(CMD_STEP, step_word(1'b1));
    send_word(CMD_TARGET, target_word(2'd1, 16'h0000));
    send_word(CMD_STEP, step_word(1'b0));
    send_word(CMD_STEP, step_word(1'b1));
    send_word(CMD_EDGE, edge_word(1'b1, 6'd0, 6'd63, 1'b1, 4'h0, 4'hF));
    send_word(CMD_STEP, step_word(1'b1));
    send_word(CMD_STEP, step_word(1'b0));
    send_word(CMD_RESTART, noise_word());
    send_word(CMD_RESTART, noise_word());

    // Fill the whole edge table so any walk reads written entries
    for (int s = 0; s < MAX_STATES; s++) begin
      for (int b = 0; b < 2; b++) begin
        send_word(CMD_EDGE, edge_word(1'(b), 6'(s), 6'($urandom_range(63)),
                                      1'($urandom_range(1)), 4'($urandom_range(15)),
                                      4'($urandom_range(15))));
      end
    end
    send_mix(240);
    drain_reports();

    send_idle_pct = 82;
    recv_idle_pct = 6;
    send_mix(370);
    drain_reports();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_mix(370);
    drain_reports();

    // Counting run: counter 0 climbs by one on every step toward a target it
    // never reaches, while the walk keeps returning to state 0
    send_word(CMD_RESTART, noise_word());
    send_word(CMD_TARGET, target_word(2'd0, 16'hFFFF));
    send_word(CMD_TARGET, target_word(2'd1, 16'h0000));
    send_word(CMD_TARGET, target_word(2'd2, 16'h0000));
    send_word(CMD_TARGET, target_word(2'd3, 16'h0000));
    send_word(CMD_EDGE, edge_word(1'b0, 6'd0, 6'd1, 1'b0, 4'h0, 4'h1));
    send_word(CMD_EDGE, edge_word(1'b1, 6'd0, 6'd0, 1'b1, 4'h0, 4'h0));
    send_word(CMD_EDGE, edge_word(1'b0, 6'd1, 6'd0, 1'b0, 4'h0, 4'h1));
    send_word(CMD_EDGE, edge_word(1'b1, 6'd1, 6'd1, 1'b1, 4'h0, 4'h0));
    for (int unsigned k = 0; k < SOAK_STEPS; k++) begin
      send_word(CMD_STEP, step_word(1'b0));
    end

    // Let the last results land and catch any stray word
    drain_reports();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
